>>> rtl/core/refraction_direction_unit_defines.svh
// Assertion macros for the refraction direction unit.
// Included by refraction_direction_unit.sv, which carries concurrent checks; no other dependencies.
`ifndef REFRACTION_DIRECTION_UNIT_DEFINES_SVH
`define REFRACTION_DIRECTION_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
// Check a property on every rising clock edge outside reset.
`define RDU_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("refraction direction unit: check failed");
// Check a property in the cycle after reset is applied.
`define RDU_ASSERT_AFTER_RESET(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) (rst) |=> (prop)) \
      else $error("refraction direction unit: reset check failed");
`else
`define RDU_ASSERT(lbl, clk, rst, prop)
`define RDU_ASSERT_AFTER_RESET(lbl, clk, rst, prop)
`endif
`endif

>>> rtl/core/rdu_pkg.sv
// Package for the refraction direction unit: fixed-point constants and the
// side-band structures that travel with the divider and square-root stages.
// No dependencies.
`default_nettype none

package rdu_pkg;

   // Working fraction bits of the cosine and the square-root terms.
   localparam int WORK_FRAC = 24;
   // Width of one vector component and of one refractive index.
   localparam int VEC_W = 16;
   localparam int IDX_W = 16;
   // Quotient bits produced by the index divider, one per stage.
   localparam int DIV_STEPS = 16;
   // Square-root radicand, root and partial remainder widths.
   localparam int RAD_W = 62;
   localparam int ROOT_W = 31;
   localparam int REM_W = 33;
   // Truncated eta*|c| term in Q.24.
   localparam int K_W = 31;
   // Saturated cosine magnitude: 4.0 in Q.24 needs 27 bits.
   localparam int CABS_W = 27;
   localparam logic [CABS_W-1:0] C_MAX = CABS_W'(64'd4 << WORK_FRAC);
   localparam logic [IDX_W-1:0] ETA_MAX = 16'hFFFF;
   // One in Q.48, held in the widths used by the two subtractions.
   localparam logic signed [53:0] ONE_Q48_54 = 54'sd1 <<< 48;
   localparam logic signed [63:0] ONE_Q48_64 = 64'sd1 <<< 48;

   // Fields carried alongside the index divider.
   typedef struct packed {
      logic                  sat;
      logic [CABS_W-1:0]     cabs;
      logic signed [16:0]    nn_x;
      logic signed [16:0]    nn_y;
      logic signed [16:0]    nn_z;
      logic signed [15:0]    w_x;
      logic signed [15:0]    w_y;
      logic signed [15:0]    w_z;
   } div_side_type;

   // Fields carried alongside the square-root unit.
   typedef struct packed {
      logic                  tir;
      logic [K_W-1:0]        k24;
      logic signed [16:0]    nn_x;
      logic signed [16:0]    nn_y;
      logic signed [16:0]    nn_z;
      logic signed [32:0]    wa_x;
      logic signed [32:0]    wa_y;
      logic signed [32:0]    wa_z;
   } sqrt_side_type;

endpackage

`default_nettype wire

>>> rtl/core/refraction_direction_unit.sv
// Refraction direction unit: fully pipelined Snell refraction of a direction vector.
// Depends on rdu_pkg and refraction_direction_unit_defines.svh.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall | wi, normal, two indices
//   rsp     | out       | rsp_valid/rsp_stall | refracted vector, reflection flag
//
// One transaction enters per cycle while the pipeline is not stalled and passes
// 56 register stages: the 16-stage index divider and the 31-stage square-root
// pipeline, one result bit per stage, plus nine set-up and arithmetic stages.
// Reset clears every stage valid bit; the payload registers are not reset.
// A stalled result freezes the whole pipeline, so req_stall follows rsp_stall while a result is valid.
`default_nettype none
`include "refraction_direction_unit_defines.svh"

module refraction_direction_unit
   import rdu_pkg::*;
#(
   parameter int VEC_FRAC_BITS = 14
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic signed [VEC_W-1:0] req_wi_x,
   input  wire logic signed [VEC_W-1:0] req_wi_y,
   input  wire logic signed [VEC_W-1:0] req_wi_z,
   input  wire logic signed [VEC_W-1:0] req_normal_x,
   input  wire logic signed [VEC_W-1:0] req_normal_y,
   input  wire logic signed [VEC_W-1:0] req_normal_z,
   input  wire logic [IDX_W-1:0]        req_index_incident,
   input  wire logic [IDX_W-1:0]        req_index_transmitted,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic signed [VEC_W-1:0]      rsp_out_x,
   output logic signed [VEC_W-1:0]      rsp_out_y,
   output logic signed [VEC_W-1:0]      rsp_out_z,
   output logic                         rsp_total_reflection
);

   localparam int TWOF = 2 * VEC_FRAC_BITS;

   // Pipeline advance: the whole pipeline moves unless a result is held.
   logic en;
   logic rsp_valid_ff;
   assign en = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;

   // Stage 1: the three component products of the dot product.
   logic               s1_valid_ff;
   logic signed [31:0] s1_px_ff, s1_py_ff, s1_pz_ff;
   logic signed [15:0] s1_wx_ff, s1_wy_ff, s1_wz_ff;
   logic signed [15:0] s1_nx_ff, s1_ny_ff, s1_nz_ff;
   logic [15:0]        s1_ii_ff, s1_it_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s1_px_ff <= 32'(req_wi_x) * 32'(req_normal_x);
         s1_py_ff <= 32'(req_wi_y) * 32'(req_normal_y);
         s1_pz_ff <= 32'(req_wi_z) * 32'(req_normal_z);
         s1_wx_ff <= req_wi_x;
         s1_wy_ff <= req_wi_y;
         s1_wz_ff <= req_wi_z;
         s1_nx_ff <= req_normal_x;
         s1_ny_ff <= req_normal_y;
         s1_nz_ff <= req_normal_z;
         s1_ii_ff <= req_index_incident;
         s1_it_ff <= req_index_transmitted;
      end
   end

   // Stage 2: sum, hemisphere choice, cosine magnitude and divider set-up.
   logic signed [33:0] dot;
   logic               pos;
   logic signed [33:0] mag;
   logic [39:0]        mag_ext;
   logic [39:0]        cabs_sh;
   logic [CABS_W-1:0]  cabs;
   logic [15:0]        num, den;
   div_side_type       s2_side_in;

   assign dot = 34'(s1_px_ff) + 34'(s1_py_ff) + 34'(s1_pz_ff);
   assign pos = dot > 34'sd0;
   assign mag = pos ? dot : -dot;
   assign mag_ext = {8'd0, mag[31:0]};

   generate
      if (TWOF >= WORK_FRAC) begin : g_cabs_right
         assign cabs_sh = mag_ext >> (TWOF - WORK_FRAC);
      end else begin : g_cabs_left
         assign cabs_sh = mag_ext << (WORK_FRAC - TWOF);
      end
   endgenerate

   always_comb begin
      cabs = (cabs_sh > 40'(C_MAX)) ? C_MAX : cabs_sh[CABS_W-1:0];
      num  = pos ? s1_ii_ff : s1_it_ff;
      den  = pos ? s1_it_ff : s1_ii_ff;
      s2_side_in.sat  = {4'd0, num} >= {den, 4'd0};
      s2_side_in.cabs = cabs;
      s2_side_in.nn_x = pos ? 17'(s1_nx_ff) : -17'(s1_nx_ff);
      s2_side_in.nn_y = pos ? 17'(s1_ny_ff) : -17'(s1_ny_ff);
      s2_side_in.nn_z = pos ? 17'(s1_nz_ff) : -17'(s1_nz_ff);
      s2_side_in.w_x  = s1_wx_ff;
      s2_side_in.w_y  = s1_wy_ff;
      s2_side_in.w_z  = s1_wz_ff;
   end

   // Index divider: one quotient bit per stage, restoring.
   logic         dv_valid_ff [0:DIV_STEPS];
   logic [15:0]  dv_rem_ff   [0:DIV_STEPS];
   logic [15:0]  dv_low_ff   [0:DIV_STEPS];
   logic [15:0]  dv_q_ff     [0:DIV_STEPS];
   logic [15:0]  dv_den_ff   [0:DIV_STEPS];
   div_side_type dv_side_ff  [0:DIV_STEPS];

   always_ff @(posedge clock) begin
      if (en) begin
         dv_rem_ff[0]  <= {4'd0, num[15:4]};
         dv_low_ff[0]  <= {num[3:0], 12'd0};
         dv_q_ff[0]    <= 16'd0;
         dv_den_ff[0]  <= den;
         dv_side_ff[0] <= s2_side_in;
      end
   end

   genvar k;
   generate
      for (k = 0; k < DIV_STEPS; k++) begin : g_div
         logic [16:0] trial;
         logic        ge;
         assign trial = {dv_rem_ff[k], dv_low_ff[k][15]};
         assign ge    = trial >= {1'b0, dv_den_ff[k]};
         always_ff @(posedge clock) begin
            if (en) begin
               dv_rem_ff[k+1]  <= ge ? 16'(trial - {1'b0, dv_den_ff[k]}) : trial[15:0];
               dv_low_ff[k+1]  <= {dv_low_ff[k][14:0], 1'b0};
               dv_q_ff[k+1]    <= {dv_q_ff[k][14:0], ge};
               dv_den_ff[k+1]  <= dv_den_ff[k];
               dv_side_ff[k+1] <= dv_side_ff[k];
            end
         end
      end
   endgenerate

   // Stage E1: relative index and the products that depend on it.
   div_side_type       dv_out;
   logic [15:0]        eta;
   logic [42:0]        eta_cabs;
   logic signed [16:0] eta_s;
   logic               e1_valid_ff;
   logic [31:0]        e1_etasq_ff;
   logic [52:0]        e1_csq_ff;
   logic [K_W-1:0]     e1_k24_ff;
   logic signed [16:0] e1_nnx_ff, e1_nny_ff, e1_nnz_ff;
   logic signed [32:0] e1_wax_ff, e1_way_ff, e1_waz_ff;

   assign dv_out   = dv_side_ff[DIV_STEPS];
   assign eta      = dv_out.sat ? ETA_MAX : dv_q_ff[DIV_STEPS];
   assign eta_s    = $signed({1'b0, eta});
   assign eta_cabs = 43'(eta) * 43'(dv_out.cabs);

   always_ff @(posedge clock) begin
      if (en) begin
         e1_etasq_ff <= 32'(eta) * 32'(eta);
         e1_csq_ff   <= 53'(dv_out.cabs) * 53'(dv_out.cabs);
         e1_k24_ff   <= eta_cabs[42:12];
         e1_nnx_ff   <= dv_out.nn_x;
         e1_nny_ff   <= dv_out.nn_y;
         e1_nnz_ff   <= dv_out.nn_z;
         e1_wax_ff   <= 33'(dv_out.w_x) * 33'(eta_s);
         e1_way_ff   <= 33'(dv_out.w_y) * 33'(eta_s);
         e1_waz_ff   <= 33'(dv_out.w_z) * 33'(eta_s);
      end
   end

   // Stage E2: one minus cosine squared, floored to Q.24.
   logic signed [53:0] omc_full;
   logic               e2_valid_ff;
   logic signed [29:0] e2_omc_ff;
   logic [31:0]        e2_etasq_ff;
   sqrt_side_type      e2_side_ff;

   assign omc_full = ONE_Q48_54 - $signed({1'b0, e1_csq_ff});

   always_ff @(posedge clock) begin
      if (en) begin
         e2_omc_ff        <= omc_full[53:24];
         e2_etasq_ff      <= e1_etasq_ff;
         e2_side_ff.tir   <= 1'b0;
         e2_side_ff.k24   <= e1_k24_ff;
         e2_side_ff.nn_x  <= e1_nnx_ff;
         e2_side_ff.nn_y  <= e1_nny_ff;
         e2_side_ff.nn_z  <= e1_nnz_ff;
         e2_side_ff.wa_x  <= e1_wax_ff;
         e2_side_ff.wa_y  <= e1_way_ff;
         e2_side_ff.wa_z  <= e1_waz_ff;
      end
   end

   // Stage E3: squared sine of the transmitted angle in Q.48.
   logic               e3_valid_ff;
   logic signed [62:0] e3_sin2_ff;
   sqrt_side_type      e3_side_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         e3_sin2_ff <= 63'($signed({1'b0, e2_etasq_ff})) * 63'(e2_omc_ff);
         e3_side_ff <= e2_side_ff;
      end
   end

   // Stage E4: reflection test and the square-root radicand.
   logic signed [63:0] rad_full;
   logic               tir;
   sqrt_side_type      e4_side_in;

   assign rad_full = ONE_Q48_64 - 64'(e3_sin2_ff);
   assign tir      = 64'(e3_sin2_ff) > ONE_Q48_64;

   always_comb begin
      e4_side_in     = e3_side_ff;
      e4_side_in.tir = tir;
   end

   // Square-root pipeline: one root bit per stage.
   logic               sq_valid_ff [0:ROOT_W];
   logic [RAD_W-1:0]   sq_rad_ff   [0:ROOT_W];
   logic [REM_W-1:0]   sq_rem_ff   [0:ROOT_W];
   logic [ROOT_W-1:0]  sq_root_ff  [0:ROOT_W];
   sqrt_side_type      sq_side_ff  [0:ROOT_W];

   always_ff @(posedge clock) begin
      if (en) begin
         sq_rad_ff[0]  <= tir ? '0 : rad_full[RAD_W-1:0];
         sq_rem_ff[0]  <= '0;
         sq_root_ff[0] <= '0;
         sq_side_ff[0] <= e4_side_in;
      end
   end

   genvar j;
   generate
      for (j = 0; j < ROOT_W; j++) begin : g_sqrt
         logic [REM_W+1:0] rem2;
         logic [REM_W+1:0] trial;
         logic             ge;
         assign rem2  = {sq_rem_ff[j], sq_rad_ff[j][RAD_W-1:RAD_W-2]};
         assign trial = {2'b00, sq_root_ff[j], 2'b01};
         assign ge    = rem2 >= trial;
         always_ff @(posedge clock) begin
            if (en) begin
               sq_rem_ff[j+1]  <= ge ? REM_W'(rem2 - trial) : rem2[REM_W-1:0];
               sq_root_ff[j+1] <= {sq_root_ff[j][ROOT_W-2:0], ge};
               sq_rad_ff[j+1]  <= {sq_rad_ff[j][RAD_W-3:0], 2'b00};
               sq_side_ff[j+1] <= sq_side_ff[j];
            end
         end
      end
   endgenerate

   // Stage F1: normal coefficient eta*|c| - cos(theta_t).
   sqrt_side_type      sq_out;
   logic               f1_valid_ff;
   logic signed [32:0] f1_coef_ff;
   sqrt_side_type      f1_side_ff;

   assign sq_out = sq_side_ff[ROOT_W];

   always_ff @(posedge clock) begin
      if (en) begin
         f1_coef_ff <= $signed({2'b00, sq_out.k24}) - $signed({2'b00, sq_root_ff[ROOT_W]});
         f1_side_ff <= sq_out;
      end
   end

   // Stage F2: the two terms of each component.
   logic               f2_valid_ff;
   logic               f2_tir_ff;
   logic signed [45:0] f2_ax_ff, f2_ay_ff, f2_az_ff;
   logic signed [49:0] f2_bx_ff, f2_by_ff, f2_bz_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         f2_tir_ff <= f1_side_ff.tir;
         f2_ax_ff  <= {-34'(f1_side_ff.wa_x), 12'd0};
         f2_ay_ff  <= {-34'(f1_side_ff.wa_y), 12'd0};
         f2_az_ff  <= {-34'(f1_side_ff.wa_z), 12'd0};
         f2_bx_ff  <= 50'(f1_side_ff.nn_x) * 50'(f1_coef_ff);
         f2_by_ff  <= 50'(f1_side_ff.nn_y) * 50'(f1_coef_ff);
         f2_bz_ff  <= 50'(f1_side_ff.nn_z) * 50'(f1_coef_ff);
      end
   end

   // Final stage: floor to the output format and saturate, or zero on total reflection.
   function automatic logic signed [15:0] sat_comp(input logic signed [45:0] a,
                                                  input logic signed [49:0] b);
      logic signed [50:0] sum;
      logic signed [26:0] q;
      sum = 51'(a) + 51'(b);
      q   = sum[50:24];
      if (q > 27'sd32767) begin
         sat_comp = 16'sh7FFF;
      end else if (q < -27'sd32768) begin
         sat_comp = 16'sh8000;
      end else begin
         sat_comp = q[15:0];
      end
   endfunction

   logic signed [15:0] out_x_ff, out_y_ff, out_z_ff;
   logic               tir_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         tir_ff   <= f2_tir_ff;
         out_x_ff <= f2_tir_ff ? 16'sd0 : sat_comp(f2_ax_ff, f2_bx_ff);
         out_y_ff <= f2_tir_ff ? 16'sd0 : sat_comp(f2_ay_ff, f2_by_ff);
         out_z_ff <= f2_tir_ff ? 16'sd0 : sat_comp(f2_az_ff, f2_bz_ff);
      end
   end

   // Valid bits travel with the data; reset empties the pipeline.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         dv_valid_ff[0] <= 1'b0;
         e1_valid_ff    <= 1'b0;
         e2_valid_ff    <= 1'b0;
         e3_valid_ff    <= 1'b0;
         sq_valid_ff[0] <= 1'b0;
         f1_valid_ff    <= 1'b0;
         f2_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else if (en) begin
         s1_valid_ff    <= req_valid;
         dv_valid_ff[0] <= s1_valid_ff;
         e1_valid_ff    <= dv_valid_ff[DIV_STEPS];
         e2_valid_ff    <= e1_valid_ff;
         e3_valid_ff    <= e2_valid_ff;
         sq_valid_ff[0] <= e3_valid_ff;
         f1_valid_ff    <= sq_valid_ff[ROOT_W];
         f2_valid_ff    <= f1_valid_ff;
         rsp_valid_ff   <= f2_valid_ff;
      end
   end

   genvar v;
   generate
      for (v = 0; v < DIV_STEPS; v++) begin : g_div_valid
         always_ff @(posedge clock) begin
            if (reset) begin
               dv_valid_ff[v+1] <= 1'b0;
            end else if (en) begin
               dv_valid_ff[v+1] <= dv_valid_ff[v];
            end
         end
      end
      for (v = 0; v < ROOT_W; v++) begin : g_sq_valid
         always_ff @(posedge clock) begin
            if (reset) begin
               sq_valid_ff[v+1] <= 1'b0;
            end else if (en) begin
               sq_valid_ff[v+1] <= sq_valid_ff[v];
            end
         end
      end
   endgenerate

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_out_x            = out_x_ff;
   assign rsp_out_y            = out_y_ff;
   assign rsp_out_z            = out_z_ff;
   assign rsp_total_reflection = tir_ff;

   // Checks on the arithmetic units and the result.
   `RDU_ASSERT(a_div_rem_below_den, clock, reset, (dv_valid_ff[DIV_STEPS] && !dv_out.sat) |-> (dv_rem_ff[DIV_STEPS] < dv_den_ff[DIV_STEPS]))
   `RDU_ASSERT(a_sqrt_rem_bound, clock, reset, sq_valid_ff[ROOT_W] |-> (34'(sq_rem_ff[ROOT_W]) <= {2'b00, sq_root_ff[ROOT_W], 1'b0}))
   `RDU_ASSERT(a_tir_zero_vector, clock, reset, (rsp_valid && rsp_total_reflection) |-> (rsp_out_x == 16'sd0 && rsp_out_y == 16'sd0 && rsp_out_z == 16'sd0))
   `RDU_ASSERT_AFTER_RESET(a_reset_empties, clock, reset, !rsp_valid && !f2_valid_ff && !sq_valid_ff[0])

endmodule

`default_nettype wire

>>> tb/refraction_direction_unit_test.sv
// Self-checking testbench for the refraction direction unit: directed table then random rays.
// Depends on rdu_pkg and the refraction_direction_unit RTL.
`default_nettype none

module refraction_direction_unit_test
   import rdu_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC = 14;
   localparam int LATENCY = 56;

   typedef struct {
      logic signed [15:0] x, y, z;
      logic               tir;
   } ray_out_type;

   typedef struct {
      logic signed [15:0] wx, wy, wz, nx, ny, nz;
      logic [15:0]        ni, nt;
      logic               known;
      ray_out_type        res;
   } ray_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [15:0] req_wi_x = '0, req_wi_y = '0, req_wi_z = '0;
   logic signed [15:0] req_normal_x = '0, req_normal_y = '0, req_normal_z = '0;
   logic [15:0] req_index_incident = '0, req_index_transmitted = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [15:0] rsp_out_x, rsp_out_y, rsp_out_z;
   logic rsp_total_reflection;

   ray_out_type expected_rays[$];
   int errors = 0;
   int sent = 0;
   int received = 0;
   int tir_seen = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_off = 0;

   refraction_direction_unit #(.VEC_FRAC_BITS(FRAC)) u_top (.*);

   // Free-running clock.
   initial begin
      forever #6 clock = ~clock;
   end

   // Safety net in case the block hangs.
   initial begin
      #20ms;
      $display("Some tests failed");
      $finish;
   end

   // Floor of an arithmetic right shift.
   function automatic longint floor_div2(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint root_floor(longint v);
      longint r = 0;
      longint b = longint'(1) << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - r - b;
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic signed [15:0] clamp16(longint v);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
   endfunction

   // Predicts the refracted direction for one ray.
   function automatic ray_out_type refract_ray(ray_row_type r);
      ray_out_type o;
      longint w[3], n[3], nn[3];
      longint dotp, cabs, num, den, eta, omc, sin2, cost, k24, coef, a, b;
      logic pos;
      w = '{longint'(r.wx), longint'(r.wy), longint'(r.wz)};
      n = '{longint'(r.nx), longint'(r.ny), longint'(r.nz)};
      dotp = w[0]*n[0] + w[1]*n[1] + w[2]*n[2];
      pos = dotp > 0;
      for (int i = 0; i < 3; i++) nn[i] = pos ? n[i] : -n[i];
      cabs = dotp < 0 ? -dotp : dotp;
      if (2*FRAC >= WORK_FRAC) cabs = cabs >> (2*FRAC - WORK_FRAC);
      else cabs = cabs << (WORK_FRAC - 2*FRAC);
      if (cabs > (longint'(4) << WORK_FRAC)) cabs = longint'(4) << WORK_FRAC;
      num = pos ? r.ni : r.nt;
      den = pos ? r.nt : r.ni;
      if (den == 0) eta = 65535;
      else begin
         eta = (num << 12) / den;
         if (eta > 65535) eta = 65535;
      end
      omc = floor_div2((longint'(1) << 48) - cabs*cabs, WORK_FRAC);
      sin2 = eta*eta*omc;
      o = '{x: 0, y: 0, z: 0, tir: 1'b1};
      if (sin2 > (longint'(1) << 48)) return o;
      o.tir = 1'b0;
      cost = root_floor((longint'(1) << 48) - sin2);
      k24 = (eta*cabs) >> 12;
      coef = k24 - cost;
      for (int i = 0; i < 3; i++) begin
         a = -(w[i]*eta) * 4096;
         b = nn[i]*coef;
         if (i == 0) o.x = clamp16(floor_div2(a + b, WORK_FRAC));
         if (i == 1) o.y = clamp16(floor_div2(a + b, WORK_FRAC));
         if (i == 2) o.z = clamp16(floor_div2(a + b, WORK_FRAC));
      end
      return o;
   endfunction

   // Offers one ray and waits for its transaction to be accepted.
   task automatic send_ray(ray_row_type r);
      ray_out_type o;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_wi_x <= r.wx; req_wi_y <= r.wy; req_wi_z <= r.wz;
      req_normal_x <= r.nx; req_normal_y <= r.ny; req_normal_z <= r.nz;
      req_index_incident <= r.ni; req_index_transmitted <= r.nt;
      o = r.known ? r.res : refract_ray(r);
      do @(posedge clock); while (req_stall);
      expected_rays.push_back(o);
      sent++;
   endtask

   function automatic logic signed [15:0] rand_comp();
      case ($urandom_range(5))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return 16'(int'($urandom_range(32768)) - 16384);
         default: return 16'($urandom);
      endcase
   endfunction

   // Random ray: mostly one dominant axis near 1.0 with small others, else arbitrary components.
   function automatic ray_row_type rand_ray();
      ray_row_type r;
      logic signed [15:0] v[6];
      int ax;
      r.known = 1'b0;
      if ($urandom_range(9) < 7) begin
         for (int k = 0; k < 2; k++) begin
            ax = $urandom_range(2);
            for (int i = 0; i < 3; i++)
               v[3*k+i] = (i == ax) ? 16'(($urandom_range(1) ? 1 : -1) *
                  int'($urandom_range(16384, 12000)))
                  : 16'(int'($urandom_range(8000)) - 4000);
         end
      end else begin
         for (int i = 0; i < 6; i++) v[i] = rand_comp();
      end
      {r.wx, r.wy, r.wz, r.nx, r.ny, r.nz} = {v[0], v[1], v[2], v[3], v[4], v[5]};
      case ($urandom_range(3))
         0: begin
            r.ni = 16'($urandom);
            r.nt = 16'($urandom);
         end
         default: begin
            r.ni = 16'($urandom_range(8192, 4096));
            r.nt = 16'($urandom_range(8192, 4096));
         end
      endcase
      return r;
   endfunction

   // Result checker.
   always @(posedge clock) begin
      ray_out_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rays.size() == 0) begin
            $error("unexpected result transaction");
            errors++;
         end else begin
            e = expected_rays.pop_front();
            received++;
            if (rsp_total_reflection) tir_seen++;
            if (rsp_out_x !== e.x) begin
               $error("out_x expected %0d actual %0d", e.x, rsp_out_x); errors++;
            end
            if (rsp_out_y !== e.y) begin
               $error("out_y expected %0d actual %0d", e.y, rsp_out_y); errors++;
            end
            if (rsp_out_z !== e.z) begin
               $error("out_z expected %0d actual %0d", e.z, rsp_out_z); errors++;
            end
            if (rsp_total_reflection !== e.tir) begin
               $error("total_reflection expected %0b actual %0b", e.tir,
                  rsp_total_reflection);
               errors++;
            end
         end
      end
   end

   // Receiver stall generator, with an optional long hold-off.
   always @(posedge clock) begin
      if (hold_off > 0) begin
         rsp_stall <= 1'b1;
         hold_off <= hold_off - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Stimulus sequence.
   initial begin
      ray_row_type dir_rows[$];
      ray_row_type r;
      int waited;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed rows: known answers where obvious, else predicted.
      r = '{wx: 0, wy: 0, wz: 16384, nx: 0, ny: 0, nz: 16384, ni: 4096, nt: 4096,
         known: 1, res: '{x: 0, y: 0, z: -16384, tir: 0}};
      dir_rows.push_back(r);
      r = '{wx: 0, wy: 0, wz: 16384, nx: 0, ny: 0, nz: -16384, ni: 4096, nt: 4096,
         known: 1, res: '{x: 0, y: 0, z: -16384, tir: 0}};
      dir_rows.push_back(r);
      r = '{wx: 16384, wy: 0, wz: 0, nx: 0, ny: 0, nz: 16384, ni: 4096, nt: 8192,
         known: 1, res: '{x: 0, y: 0, z: 0, tir: 1}};
      dir_rows.push_back(r);
      r = '{wx: 11585, wy: 0, wz: 11585, nx: 0, ny: 0, nz: 16384, ni: 1, nt: 65535,
         known: 0, res: '{x: 0, y: 0, z: 0, tir: 0}};
      dir_rows.push_back(r);
      r = '{wx: 11585, wy: 0, wz: 11585, nx: 0, ny: 0, nz: 16384, ni: 0, nt: 6144,
         known: 0, res: '{x: 0, y: 0, z: 0, tir: 0}};
      dir_rows.push_back(r);
      r = '{wx: 11585, wy: 0, wz: -11585, nx: 0, ny: 0, nz: 16384, ni: 6144, nt: 0,
         known: 0, res: '{x: 0, y: 0, z: 0, tir: 0}};
      dir_rows.push_back(r);
      r = '{wx: -32768, wy: -32768, wz: -32768, nx: -32768, ny: -32768, nz: -32768,
         ni: 65535, nt: 65535, known: 0, res: '{x: 0, y: 0, z: 0, tir: 0}};
      dir_rows.push_back(r);
      r = '{wx: 32767, wy: 32767, wz: 32767, nx: -32768, ny: 32767, nz: 32767,
         ni: 4096, nt: 6144, known: 0, res: '{x: 0, y: 0, z: 0, tir: 0}};
      dir_rows.push_back(r);
      r = '{wx: 0, wy: 0, wz: 0, nx: 0, ny: 0, nz: 0, ni: 0, nt: 0,
         known: 0, res: '{x: 0, y: 0, z: 0, tir: 0}};
      dir_rows.push_back(r);
      r = '{wx: 32767, wy: -32768, wz: 0, nx: 0, ny: 32767, nz: -32768,
         ni: 65535, nt: 1, known: 0, res: '{x: 0, y: 0, z: 0, tir: 0}};
      dir_rows.push_back(r);
      r = '{wx: 0, wy: 16384, wz: 0, nx: 16384, ny: 0, nz: 0, ni: 5000, nt: 4096,
         known: 0, res: '{x: 0, y: 0, z: 0, tir: 0}};
      dir_rows.push_back(r);
      foreach (dir_rows[i]) send_ray(dir_rows[i]);

      // Random phases with different idle and stall mixes.
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 53 : 25) : 0;
         stall_pct = (ph == 2) ? 53 : (ph == 3 ? 25 : 0);
         if (ph == 0) hold_off = 300;
         for (int i = 0; i < 335; i++) send_ray(rand_ray());
      end
      req_valid <= 1'b0;

      // Drain.
      waited = 0;
      while (expected_rays.size() != 0 && waited < 100000) begin
         @(posedge clock);
         waited++;
      end
      repeat (LATENCY + 10) @(posedge clock);
      $display("Sent %0d rays, checked %0d results, %0d total reflections.",
         sent, received, tir_seen);
      if (errors == 0 && expected_rays.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
